// ----- design/zero_one_knapsack_engine_assert.svh -----
// assertion macros shared by the knapsack engine modules
// expects signals named clk and rst in the module that uses them
`ifndef ZERO_ONE_KNAPSACK_ENGINE_ASSERT_SVH
`define ZERO_ONE_KNAPSACK_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ZOKE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ZOKE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/zoke_pkg.sv -----
// shared types for the knapsack engine
// used by zoke_ctrl, zoke_datapath and zero_one_knapsack_engine
package zoke_pkg;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_item;  // latch weight, value and last mark
    logic rd_sweep;   // read entries c and c - weight, write back next cycle
    logic rd_cap;     // read the entry at the configured capacity
    logic load_out;   // move the read entry into the output register
    logic set_fresh;  // table counts as all zeros from the next item on
    logic clr_fresh;  // table holds real data after this sweep
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;      // current item closes the set
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

// ----- design/zero_one_knapsack_engine.sv -----
// top level of the 0/1 knapsack engine
// depends on zoke_pkg, zoke_ctrl and zoke_datapath
//
// Usage:
//   Items enter on in_valid/in_stall with item_weight, item_value and
//   last_item; an item is taken when in_valid is high and in_stall low.
//   Each item sweeps the whole best-value table once, from the top entry
//   down, one entry per clock through the single table write port, then
//   passes a write-back flush state and returns to idle to take the next
//   item. An item marked last adds a read of the entry at the configured
//   capacity and a load of it into the output register; best_value then
//   appears with out_valid, and the table counts as all zeros for the next
//   set. The result sits in an output register: while out_stall holds it,
//   the engine still takes and sweeps further items, and only a following
//   last item waits for the register to empty.
//   capacity is written on cfg_valid/cfg_ready (always ready); the user
//   must write it only while idle, the engine does not enforce this.
//   Synchronous reset clears the control state, the capacity register
//   and marks the table as all zeros; no clearing pass is needed.
module zero_one_knapsack_engine import zoke_pkg::*; #(
  parameter int CAP_MAX     = 1023,
  parameter int VALUE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  item_weight,
  input  logic [15:0] item_value,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] best_value
);

  localparam int ADDR_W = (CAP_MAX > 1) ? $clog2(CAP_MAX + 1) : 1;

  cmd_t              cmd;
  sts_t              sts;
  logic [ADDR_W-1:0] addr;

  assign cfg_ready = 1'b1;

  // sequencer
  zoke_ctrl #(
    .CAP_MAX (CAP_MAX),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .addr     (addr)
  );

  // table and arithmetic
  zoke_datapath #(
    .CAP_MAX     (CAP_MAX),
    .VALUE_WIDTH (VALUE_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .addr        (addr),
    .sts         (sts),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .item_weight (item_weight),
    .item_value  (item_value),
    .last_item   (last_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .best_value  (best_value)
  );

endmodule

// ----- design/zoke_ctrl.sv -----
// controller state machine for the knapsack engine
// depends on zoke_pkg and zero_one_knapsack_engine_assert.svh
`include "zero_one_knapsack_engine_assert.svh"

module zoke_ctrl import zoke_pkg::*; #(
  parameter int CAP_MAX = 1023,
  parameter int ADDR_W  = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sts_t              sts,
  output cmd_t              cmd,
  output logic [ADDR_W-1:0] addr
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_FLUSH,
    S_READ,
    S_LOAD
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] count;

  assign addr     = count;
  assign in_stall = (state != S_IDLE);

  // decode commands from the current state
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:  cmd.load_item = in_valid;
      S_SWEEP: cmd.rd_sweep  = 1'b1;
      S_FLUSH: cmd.clr_fresh = 1'b1;
      S_READ:  cmd.rd_cap    = 1'b1;
      S_LOAD: begin
        cmd.load_out  = sts.out_free;
        cmd.set_fresh = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  // state and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SWEEP;
            count <= ADDR_W'(CAP_MAX);
          end
        end
        S_SWEEP: begin
          if (count == '0) begin
            state <= S_FLUSH;
          end else begin
            count <= count - 1'b1;
          end
        end
        S_FLUSH: begin
          state <= sts.last ? S_READ : S_IDLE;
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ZOKE_ASSERT_NEXT(a_sweep_ends, (state == S_SWEEP) && (count == '0), state == S_FLUSH, "sweep did not end at entry zero")
  `ZOKE_ASSERT_NEXT(a_accept_starts_top, in_valid && !in_stall, (state == S_SWEEP) && (count == ADDR_W'(CAP_MAX)), "sweep did not start at the top entry")
  `ZOKE_ASSERT_NOW(a_load_has_room, cmd.load_out, sts.out_free && (state == S_LOAD), "result loaded without room")

endmodule

// ----- design/zoke_datapath.sv -----
// table memory, update pipeline and output register of the knapsack engine
// depends on zoke_pkg and zero_one_knapsack_engine_assert.svh
`include "zero_one_knapsack_engine_assert.svh"

module zoke_datapath import zoke_pkg::*; #(
  parameter int CAP_MAX     = 1023,
  parameter int VALUE_WIDTH = 16,
  parameter int ADDR_W      = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic [ADDR_W-1:0] addr,
  output sts_t              sts,
  input  logic              cfg_we,
  input  logic [9:0]        cfg_data,
  input  logic [9:0]        item_weight,
  input  logic [15:0]       item_value,
  input  logic              last_item,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       best_value
);

  localparam int VW = (VALUE_WIDTH < 16) ? VALUE_WIDTH : 16;

  logic [31:0]       mem [0:CAP_MAX];
  logic [9:0]        capacity;
  logic [9:0]        weight_q;
  logic [VW-1:0]     val_q;
  logic              last_q;
  logic              fresh;
  logic [31:0]       rd_c_q;
  logic [31:0]       rd_lo_q;
  logic              wr_pending;
  logic [ADDR_W-1:0] wr_addr;
  logic              fits_d;
  logic [ADDR_W-1:0] cap_addr;
  logic [ADDR_W-1:0] lo_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              fits;
  logic [31:0]       old_c;
  logic [31:0]       old_lo;
  logic [32:0]       sum;
  logic [31:0]       cand;
  logic [31:0]       new_c;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      weight_q <= item_weight;
      val_q    <= item_value[VW-1:0];
      last_q   <= last_item;
    end
  end

  // fresh mark stands for a table of zeros without a clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= 1'b1;
    end else if (cmd.set_fresh) begin
      fresh <= 1'b1;
    end else if (cmd.clr_fresh) begin
      fresh <= 1'b0;
    end
  end

  // read addresses, capacity saturates at the top entry
  always_comb begin
    cap_addr = (32'(capacity) > 32'(CAP_MAX)) ? ADDR_W'(CAP_MAX) : ADDR_W'(capacity);
    fits     = 32'(addr) >= 32'(weight_q);
    lo_addr  = ADDR_W'(32'(addr) - 32'(weight_q));
    rd_addr  = cmd.rd_cap ? cap_addr : addr;
  end

  // registered table reads
  always_ff @(posedge clk) begin
    if (cmd.rd_sweep || cmd.rd_cap) begin
      rd_c_q  <= mem[rd_addr];
      rd_lo_q <= mem[lo_addr];
    end
  end

  // write-back stage tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pending <= 1'b0;
    end else begin
      wr_pending <= cmd.rd_sweep;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_sweep) begin
      wr_addr <= addr;
      fits_d  <= fits;
    end
  end

  // saturating candidate and max
  always_comb begin
    old_c  = fresh ? '0 : rd_c_q;
    old_lo = fresh ? '0 : rd_lo_q;
    sum    = {1'b0, old_lo} + 33'(val_q);
    cand   = sum[32] ? '1 : sum[31:0];
    new_c  = (fits_d && (cand > old_c)) ? cand : old_c;
  end

  always_ff @(posedge clk) begin
    if (wr_pending) begin
      mem[wr_addr] <= new_c;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      best_value <= rd_c_q;
    end
  end

  assign sts.last     = last_q;
  assign sts.out_free = !out_valid || !out_stall;

  `ZOKE_ASSERT_NOW(a_write_follows_sweep, wr_pending, $past(cmd.rd_sweep), "write-back without a sweep read")
  `ZOKE_ASSERT_NOW(a_result_after_writes, cmd.load_out || cmd.rd_cap, !wr_pending, "result read while a write is in flight")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for zero_one_knapsack_engine: directed and random knapsack sets
// with a self-checking best-value predictor; needs only the design files
module tb_top;

  localparam int CAP_MAX     = 1023;
  localparam int VALUE_WIDTH = 16;
  localparam logic [15:0] VALUE_MASK = 16'((32'd1 << VALUE_WIDTH) - 1);
  // one item sweep plus flush and the capacity read
  localparam int SWEEP_CYCLES = CAP_MAX + 8;
  // bound from the slowest legal run: every item with the longest sender gap,
  // the longest receiver stall and a full sweep, then three times over
  localparam int GAP_MAX   = 1300;
  localparam int STALL_MAX = 2500;
  localparam longint CYCLE_LIMIT =
    3 * 600 * (SWEEP_CYCLES + GAP_MAX + STALL_MAX) + 100000;

  typedef struct {
    logic [9:0]  weight;
    logic [15:0] value;
    logic        last;
  } knap_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [9:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [9:0]  item_weight = '0;
  logic [15:0] item_value = '0;
  logic        last_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] best_value;

  // predictor state
  logic [31:0] best_tab [0:CAP_MAX];
  logic [9:0]  cap_shadow = '0;
  logic [31:0] best_expect_q [$];

  knap_item_t  stim_q [$];
  int          pending_items = 0;
  int          err_count = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  logic        steady = 1'b0;
  longint      cycle_cnt = 0;

  zero_one_knapsack_engine #(
    .CAP_MAX     (CAP_MAX),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .item_weight (item_weight),
    .item_value  (item_value),
    .last_item   (last_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .best_value  (best_value)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, exp_val);
    err_count++;
  endtask

  // 0/1 knapsack update, top entry down so each item is taken at most once
  task automatic sweep_item(input logic [9:0] w, input logic [15:0] v,
                            input logic last);
    logic [15:0] vm;
    logic [32:0] cand;
    int          wi;
    int          c;
    int          cap_i;
    vm = v & VALUE_MASK;
    wi = w;
    if (wi <= CAP_MAX) begin
      for (c = CAP_MAX; c >= wi; c--) begin
        cand = {17'd0, vm} + {1'b0, best_tab[c - wi]};
        if (cand[32]) cand = 33'h0_FFFF_FFFF;
        if (cand[31:0] > best_tab[c]) best_tab[c] = cand[31:0];
      end
    end
    if (last) begin
      cap_i = cap_shadow;
      if (cap_i > CAP_MAX) cap_i = CAP_MAX;
      best_expect_q.push_back(best_tab[cap_i]);
      foreach (best_tab[i]) best_tab[i] = '0;
    end
  endtask

  task automatic queue_item(input logic [9:0] w, input logic [15:0] v,
                            input logic last);
    knap_item_t it;
    it.weight = w;
    it.value  = v;
    it.last   = last;
    stim_q.push_back(it);
    pending_items++;
  endtask

  // capacity is written only once the engine has drained and gone quiet
  task automatic set_capacity(input logic [9:0] cap);
    while (pending_items != 0 || best_expect_q.size() != 0) @(posedge clk);
    repeat (SWEEP_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cap_shadow = cap;
    cfg_valid <= 1'b0;
  endtask

  // item driver with random gaps between items
  always @(posedge clk) begin
    knap_item_t nxt;
    int r;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        sweep_item(item_weight, item_value, last_item);
        pending_items--;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          nxt = stim_q.pop_front();
          in_valid    <= 1'b1;
          item_weight <= nxt.weight;
          item_value  <= nxt.value;
          last_item   <= nxt.last;
          // long gaps land near the end of the sweep, where the engine frees up
          r = $urandom_range(0, 99);
          if (steady || r < 70) gap_left = 0;
          else if (r < 92) gap_left = $urandom_range(1, 8);
          else gap_left = $urandom_range(900, GAP_MAX);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    logic [31:0] exp_best;
    int r;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (best_expect_q.size() == 0) begin
          report_mismatch("unexpected best_value", best_value, '0);
        end else begin
          exp_best = best_expect_q.pop_front();
          if (best_value !== exp_best)
            report_mismatch("best_value", best_value, exp_best);
        end
      end
      if (stall_left == 0 && !steady) begin
        r = $urandom_range(0, 1999);
        if (r == 0) stall_left = $urandom_range(200, STALL_MAX);
        else if (r < 300) stall_left = $urandom_range(1, 4);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus
  initial begin
    int ph;
    int n;
    int r;
    logic [9:0]  cap_now;
    logic [9:0]  w;
    logic [15:0] v;

    foreach (best_tab[i]) best_tab[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset capacity of zero: zero-weight items add once each
    queue_item(10'd0, 16'hFFFF, 1'b0);
    queue_item(10'd0, 16'd1, 1'b1);
    queue_item(10'd1, 16'd500, 1'b1);

    // full capacity, heaviest item and a pair that just fills the knapsack
    set_capacity(10'd1023);
    queue_item(10'd1023, 16'hFFFF, 1'b1);
    queue_item(10'd1023, 16'hFFFF, 1'b0);
    queue_item(10'd1, 16'd0, 1'b0);
    queue_item(10'd512, 16'h8000, 1'b0);
    queue_item(10'd511, 16'h7FFF, 1'b1);

    // capacity changed between items of one set
    queue_item(10'd100, 16'd500, 1'b0);
    queue_item(10'd900, 16'd700, 1'b0);
    set_capacity(10'd99);
    queue_item(10'd0, 16'd3, 1'b1);

    // capacity of one
    set_capacity(10'd1);
    queue_item(10'd1, 16'd7, 1'b0);
    queue_item(10'd2, 16'd9, 1'b0);
    queue_item(10'd1, 16'd5, 1'b1);

    // random phases, each at its own capacity; sets may straddle a change
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: cap_now = 10'd0;
        1: cap_now = 10'd1023;
        2: cap_now = 10'd1;
        4: cap_now = 10'd512;
        5: cap_now = 10'd1023;
        default: cap_now = 10'($urandom_range(2, 1022));
      endcase
      set_capacity(cap_now);
      steady = (ph == 2 || ph == 5);
      for (n = 0; n < 72; n++) begin
        r = $urandom_range(0, 9);
        if (r < 4) w = 10'($urandom_range(0, cap_now));
        else if (r == 4) w = 10'd0;
        else if (r == 5) w = 10'd1023;
        else if (r == 6) w = cap_now;
        else w = 10'($urandom_range(0, 1023));
        r = $urandom_range(0, 9);
        if (r == 0) v = 16'd0;
        else if (r == 1) v = 16'hFFFF;
        else v = 16'($urandom_range(0, 65535));
        queue_item(w, v, $urandom_range(0, 2) == 0);
      end
    end

    // drain, then allow one more sweep for stray results
    while (pending_items != 0 || best_expect_q.size() != 0) @(posedge clk);
    repeat (SWEEP_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
